>>> design/emp_pkg.sv
// shared types and constants for the encoder move-to-position block
package emp_pkg;

  // phase codes, as reported on the result channel
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_COARSE  = 3'd1;
  localparam logic [2:0] PH_FINE    = 3'd2;
  localparam logic [2:0] PH_SETTLE  = 3'd3;
  localparam logic [2:0] PH_CORRECT = 3'd4;

  // request action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_FINE_GAIN   = 3'd0;
  localparam logic [2:0] REG_UP_SCALE    = 3'd1;
  localparam logic [2:0] REG_DOWN_SCALE  = 3'd2;
  localparam logic [2:0] REG_TOLERANCE   = 3'd3;
  localparam logic [2:0] REG_SETTLE      = 3'd4;
  localparam logic [8:0] FINE_GAIN_MAX   = 9'd256;

  // shared serial multiplier
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // coarse threshold width before saturation
  localparam int THR_W = MUL_P_W - 8;

  typedef struct packed {
    logic              action;
    logic signed [31:0] encoder_count;
    logic signed [31:0] target_position;
    logic signed [7:0]  power;
    logic              correct_enable;
  } req_t;

  typedef struct packed {
    logic signed [7:0] drive;
    logic [2:0]        phase;
    logic              done_res;
  } res_t;

  typedef struct packed {
    logic [8:0]  fine_gain;
    logic [15:0] coarse_up_scale;
    logic [15:0] coarse_down_scale;
    logic [15:0] tolerance;
    logic [7:0]  settle_ticks;
  } cfg_t;

endpackage

>>> design/emp_regs.sv
// configuration register file behind the apb-style port
module emp_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [emp_pkg::ADDR_W-1:0]  paddr,
  input  logic [emp_pkg::DATA_W-1:0]  pwdata,
  output logic [emp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output emp_pkg::cfg_t               cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[emp_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fine_gain         <= 9'd128;
      cfg.coarse_up_scale   <= 16'd141;
      cfg.coarse_down_scale <= 16'd465;
      cfg.tolerance         <= 16'd10;
      cfg.settle_ticks      <= 8'd10;
    end else if (wr_en) begin
      case (index)
        emp_pkg::REG_FINE_GAIN: begin
          // gain above unity is held at unity
          cfg.fine_gain <= (pwdata[8:0] > emp_pkg::FINE_GAIN_MAX) ?
                           emp_pkg::FINE_GAIN_MAX : pwdata[8:0];
        end
        emp_pkg::REG_UP_SCALE:   cfg.coarse_up_scale   <= pwdata[15:0];
        emp_pkg::REG_DOWN_SCALE: cfg.coarse_down_scale <= pwdata[15:0];
        emp_pkg::REG_TOLERANCE:  cfg.tolerance         <= pwdata[15:0];
        emp_pkg::REG_SETTLE:     cfg.settle_ticks      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      emp_pkg::REG_FINE_GAIN:  prdata = {23'd0, cfg.fine_gain};
      emp_pkg::REG_UP_SCALE:   prdata = {16'd0, cfg.coarse_up_scale};
      emp_pkg::REG_DOWN_SCALE: prdata = {16'd0, cfg.coarse_down_scale};
      emp_pkg::REG_TOLERANCE:  prdata = {16'd0, cfg.tolerance};
      emp_pkg::REG_SETTLE:     prdata = {24'd0, cfg.settle_ticks};
      default:                 prdata = '0;
    endcase
  end

endmodule

>>> design/emp_serial_mul.sv
// bit-serial shift-and-add multiplier, signed multiplicand by unsigned multiplier
module emp_serial_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [emp_pkg::MUL_A_W-1:0]  a,
  input  logic [emp_pkg::MUL_B_W-1:0]  b,
  output logic                         done,
  output logic [emp_pkg::MUL_P_W-1:0]  product
);

  logic                        busy;
  logic [emp_pkg::MUL_P_W-1:0] mcand;
  logic [emp_pkg::MUL_B_W-1:0] mplr;
  logic [emp_pkg::MUL_P_W-1:0] acc;

  // finishes as soon as no multiplier bits remain
  assign done    = busy && (mplr == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      mcand <= {{(emp_pkg::MUL_P_W-emp_pkg::MUL_A_W){a[emp_pkg::MUL_A_W-1]}}, a};
      mplr  <= b;
    end else if (busy && (mplr != '0)) begin
      if (mplr[0]) begin
        acc <= acc + mcand;
      end
      mcand <= mcand << 1;
      mplr  <= mplr >> 1;
    end
  end

endmodule

>>> design/encoder_move_to_position.sv
// top level of the encoder move-to-position controller for one wheel axis
//
// One wheel axis driven to an encoder target. A start request (action 0)
// latches the target (0 is taken as 1), the power magnitude and the
// correction flag, and picks the direction from the current count; its
// result is drive 0 in the coarse phase, or done at once when the count is
// already on target. Each tick request (action 1) runs coarse, fine,
// settle and correct phases in order, a satisfied phase falling through in
// the same tick, and returns one drive/phase/done result. All products go
// through one shared bit-serial multiplier that retires one multiplier bit
// per cycle and stops at the highest set bit. A start runs through S_ST0,
// S_ST1 (waiting on the threshold product) and S_EMIT, or through S_ST0
// and S_EMIT when the count already sits on the target; a tick runs through
// S_TK0, S_TK1 and S_TK2 (waiting on the two gain products), S_DEC and
// S_EMIT. One request is worked on at a time; the next is taken as soon as
// the result sits in the output register, even while that result waits on
// res_stall. COUNT_WIDTH sets the signed range to which the coarse
// threshold saturates.
module encoder_move_to_position #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        req_valid,
  output logic                        req_stall,
  input  emp_pkg::req_t               req_data,
  // result channel
  output logic                        res_valid,
  input  logic                        res_stall,
  output emp_pkg::res_t               res_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [emp_pkg::ADDR_W-1:0]  paddr,
  input  logic [emp_pkg::DATA_W-1:0]  pwdata,
  output logic [emp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // saturation width, no narrower than needed and never wider than the raw threshold
  localparam int CLAMP_W = (COUNT_WIDTH < emp_pkg::THR_W) ? COUNT_WIDTH : emp_pkg::THR_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_ST0  = 3'd1;  // start: latch operands, launch threshold product
  localparam logic [2:0] S_ST1  = 3'd2;  // start: wait product, form threshold
  localparam logic [2:0] S_TK0  = 3'd3;  // tick: launch power * gain, form tolerance band
  localparam logic [2:0] S_TK1  = 3'd4;  // tick: wait power * gain, launch times gain again
  localparam logic [2:0] S_TK2  = 3'd5;  // tick: wait power * gain squared
  localparam logic [2:0] S_DEC  = 3'd6;  // tick: run the phase chain
  localparam logic [2:0] S_EMIT = 3'd7;  // hand the result to the output register

  emp_pkg::cfg_t cfg;

  logic [2:0]    state;
  emp_pkg::req_t req_q;
  emp_pkg::res_t pend;

  // move state
  logic [2:0]                      move_phase;
  logic                            direction_down;
  logic signed [31:0]              goal;
  logic signed [emp_pkg::THR_W-1:0] coarse_threshold;
  logic [6:0]                      power_magnitude;
  logic                            correction_on;
  logic [7:0]                      settle_count;
  logic [7:0]                      last_drive;

  // per-tick working values
  logic signed [33:0] band_lo;
  logic signed [33:0] band_hi;
  logic [7:0]         fine_mag;
  logic [7:0]         corr_mag;

  // shared multiplier
  logic                          mul_start;
  logic [emp_pkg::MUL_A_W-1:0]   mul_a;
  logic [emp_pkg::MUL_B_W-1:0]   mul_b;
  logic                          mul_done;
  logic [emp_pkg::MUL_P_W-1:0]   mul_p;

  emp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  emp_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  assign req_stall = (state != S_IDLE);

  // start operands: zero target becomes one, most negative power saturates
  logic signed [31:0] tgt_eff;
  logic [7:0]         pwr_abs;
  logic [6:0]         pwr_mag;
  logic               cnt_below;
  logic               cnt_above;

  assign tgt_eff   = (req_q.target_position == 32'sd0) ? 32'sd1 : req_q.target_position;
  assign pwr_abs   = req_q.power[7] ? (~req_q.power + 8'd1) : req_q.power;
  assign pwr_mag   = pwr_abs[7] ? 7'h7f : pwr_abs[6:0];
  assign cnt_below = req_q.encoder_count < tgt_eff;
  assign cnt_above = req_q.encoder_count > tgt_eff;

  // coarse threshold: ceil for upward moves, floor for downward, then saturate
  logic [emp_pkg::MUL_P_W-1:0]      prod_ceil;
  logic signed [emp_pkg::THR_W-1:0] thr_raw;
  logic                             thr_fits;
  logic signed [emp_pkg::THR_W-1:0] thr_sat;

  assign prod_ceil = mul_p + emp_pkg::MUL_P_W'(255);
  assign thr_raw   = direction_down ? mul_p[emp_pkg::MUL_P_W-1:8]
                                    : prod_ceil[emp_pkg::MUL_P_W-1:8];
  assign thr_fits  = (&thr_raw[emp_pkg::THR_W-1:CLAMP_W-1]) |
                     ~(|thr_raw[emp_pkg::THR_W-1:CLAMP_W-1]);
  assign thr_sat   = thr_fits ? thr_raw :
                     thr_raw[emp_pkg::THR_W-1] ?
                       {{(emp_pkg::THR_W-CLAMP_W+1){1'b1}}, {(CLAMP_W-1){1'b0}}} :
                       {{(emp_pkg::THR_W-CLAMP_W+1){1'b0}}, {(CLAMP_W-1){1'b1}}};

  // multiplier operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      S_ST0: begin
        mul_start = cnt_below | cnt_above;
        mul_a     = tgt_eff;
        mul_b     = cnt_above ? cfg.coarse_down_scale : cfg.coarse_up_scale;
      end
      S_TK0: begin
        mul_start = 1'b1;
        mul_a     = {25'd0, power_magnitude};
        mul_b     = {7'd0, cfg.fine_gain};
      end
      S_TK1: begin
        // power * gain fits 16 bits; multiply by gain once more
        mul_start = mul_done;
        mul_a     = {16'd0, mul_p[15:0]};
        mul_b     = {7'd0, cfg.fine_gain};
      end
      default: ;
    endcase
  end

  // phase chain for a tick, with fall-through inside one tick
  logic signed [emp_pkg::THR_W-1:0] cnt_wide;
  logic signed [33:0]               cnt_band;
  logic                             coarse_go;
  logic                             fine_go;
  logic                             corr_go;
  logic [2:0]                       dec_phase;
  logic [7:0]                       dec_settle;
  logic                             dec_finish;
  logic                             dec_drv;
  logic                             dec_hold;
  logic [7:0]                       dec_mag;
  logic                             dec_neg;
  logic [7:0]                       dec_drive;

  assign cnt_wide  = {{(emp_pkg::THR_W-32){req_q.encoder_count[31]}}, req_q.encoder_count};
  assign cnt_band  = {{2{req_q.encoder_count[31]}}, req_q.encoder_count};
  assign coarse_go = direction_down ? (cnt_wide > coarse_threshold)
                                    : (cnt_wide < coarse_threshold);
  assign fine_go   = direction_down ? (cnt_band > band_hi) : (cnt_band < band_lo);
  assign corr_go   = direction_down ? (cnt_band < band_lo) : (cnt_band > band_hi);

  always_comb begin
    dec_phase  = move_phase;
    dec_settle = settle_count;
    dec_finish = 1'b0;
    dec_drv    = 1'b0;
    dec_hold   = 1'b0;
    dec_mag    = 8'd0;
    dec_neg    = 1'b0;
    if (dec_phase == emp_pkg::PH_IDLE || dec_phase > emp_pkg::PH_CORRECT) begin
      dec_finish = 1'b1;
    end else begin
      if (dec_phase == emp_pkg::PH_COARSE) begin
        if (coarse_go) begin
          dec_drv = 1'b1;
          dec_mag = {1'b0, power_magnitude};
          dec_neg = direction_down;
        end else begin
          dec_phase = emp_pkg::PH_FINE;
        end
      end
      if (!dec_drv && dec_phase == emp_pkg::PH_FINE) begin
        if (fine_go) begin
          dec_drv = 1'b1;
          dec_mag = fine_mag;
          dec_neg = direction_down;
        end else if (!correction_on) begin
          dec_finish = 1'b1;
        end else begin
          dec_phase  = emp_pkg::PH_SETTLE;
          dec_settle = 8'd0;
        end
      end
      if (!dec_drv && !dec_finish && dec_phase == emp_pkg::PH_SETTLE) begin
        if (dec_settle < cfg.settle_ticks) begin
          dec_hold   = 1'b1;
          dec_settle = dec_settle + 8'd1;
        end else begin
          dec_phase = emp_pkg::PH_CORRECT;
        end
      end
      if (!dec_drv && !dec_finish && !dec_hold) begin
        // correction drives back towards the goal
        if (corr_go) begin
          dec_drv = 1'b1;
          dec_mag = corr_mag;
          dec_neg = ~direction_down;
        end else begin
          dec_finish = 1'b1;
        end
      end
    end
  end

  assign dec_drive = dec_neg ? (8'd0 - dec_mag) : dec_mag;

  // sequencer and move state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      move_phase     <= emp_pkg::PH_IDLE;
      direction_down <= 1'b0;
      goal           <= '0;
      coarse_threshold <= '0;
      power_magnitude <= '0;
      correction_on  <= 1'b0;
      settle_count   <= '0;
      last_drive     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= (req_data.action == emp_pkg::ACT_START) ? S_ST0 : S_TK0;
          end
        end
        S_ST0: begin
          goal            <= tgt_eff;
          power_magnitude <= pwr_mag;
          correction_on   <= req_q.correct_enable;
          settle_count    <= 8'd0;
          last_drive      <= 8'd0;
          if (cnt_below | cnt_above) begin
            direction_down <= cnt_above;
            state          <= S_ST1;
          end else begin
            // already on target: done at once
            move_phase <= emp_pkg::PH_IDLE;
            state      <= S_EMIT;
          end
        end
        S_ST1: begin
          if (mul_done) begin
            coarse_threshold <= thr_sat;
            move_phase       <= emp_pkg::PH_COARSE;
            state            <= S_EMIT;
          end
        end
        S_TK0: begin
          state <= S_TK1;
        end
        S_TK1: begin
          if (mul_done) begin
            state <= S_TK2;
          end
        end
        S_TK2: begin
          if (mul_done) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          settle_count <= dec_settle;
          if (dec_finish) begin
            move_phase <= emp_pkg::PH_IDLE;
            last_drive <= 8'd0;
          end else if (dec_hold) begin
            move_phase <= emp_pkg::PH_SETTLE;
          end else begin
            move_phase <= dec_phase;
            last_drive <= dec_drive;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_valid || !res_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request latch, working values and pending result
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req_data;
    end
    if (state == S_TK0) begin
      band_lo <= {{2{goal[31]}}, goal} - {18'd0, cfg.tolerance};
      band_hi <= {{2{goal[31]}}, goal} + {18'd0, cfg.tolerance};
    end
    if (state == S_TK1 && mul_done) begin
      fine_mag <= mul_p[15:8];
    end
    if (state == S_TK2 && mul_done) begin
      corr_mag <= mul_p[23:16];
    end
    case (state)
      S_ST0: begin
        pend.drive    <= 8'sd0;
        pend.phase    <= emp_pkg::PH_IDLE;
        pend.done_res <= 1'b1;
      end
      S_ST1: begin
        pend.drive    <= 8'sd0;
        pend.phase    <= emp_pkg::PH_COARSE;
        pend.done_res <= 1'b0;
      end
      S_DEC: begin
        if (dec_finish) begin
          pend.drive    <= 8'sd0;
          pend.phase    <= emp_pkg::PH_IDLE;
          pend.done_res <= 1'b1;
        end else if (dec_hold) begin
          pend.drive    <= last_drive;
          pend.phase    <= emp_pkg::PH_SETTLE;
          pend.done_res <= 1'b0;
        end else begin
          pend.drive    <= dec_drive;
          pend.phase    <= dec_phase;
          pend.done_res <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register, parts the two channels
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_EMIT && (!res_valid || !res_stall)) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!res_valid || !res_stall)) begin
      res_data <= pend;
    end
  end

`ifndef SYNTHESIS
  // the multiplier only finishes while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_ST1 || state == S_TK1 || state == S_TK2))
    else $error("multiplier finished outside a wait state");

  // a free output slot takes the pending result at once
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!res_valid || !res_stall)) |=> res_valid)
    else $error("pending result not moved to output");

  // a new result only appears after the hand-over state
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_EMIT)
    else $error("result raised without hand-over");

  // done flag and idle phase always agree, and done carries no drive
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.done_res == (res_data.phase == emp_pkg::PH_IDLE)))
    else $error("done flag disagrees with phase");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.done_res) |-> (res_data.drive == 8'sd0))
    else $error("finished move with non-zero drive");
`endif

endmodule
